[hw/rtl/polg_pkg.sv]
// Shared types and constants for the parallel offset line generator.
// Holds the request and result structs and the configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package polg_pkg;

	localparam int MAX_COPIES = 32;
	localparam int COORD_W    = 32;
	localparam int CNT_W      = 6;
	localparam int GAP_W      = 31;
	localparam int NORM_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Unit length in the Q1.16 normal format.
	localparam logic [NORM_W-1:0] NORM_ONE = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] REG_COPIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} polg_seg_t;

	typedef struct packed {
		logic                      side;
		logic [CNT_W-1:0]          copy_index;
		logic signed [COORD_W-1:0] seg_start_x;
		logic signed [COORD_W-1:0] seg_start_y;
		logic signed [COORD_W-1:0] seg_end_x;
		logic signed [COORD_W-1:0] seg_end_y;
		logic                      last;
	} polg_res_t;

endpackage

`default_nettype wire

[hw/rtl/parallel_offset_line_generator.sv]
// Top level of the parallel offset line generator: normal computation and copy emission.
// Depends on polg_pkg for the segment and result structs and register indexes.
//
// Usage: write copies_per_side (index 0) and gap (index 1) on the cfg channel while
// the block is idle; cfg_ready is always high. A segment request is taken when start
// is high and busy is low. The block then emits up to 2*N results, one per
// result_strobe pulse: copies 1..N on the right of the travel direction, then 1..N on
// the left, with last set on the final one. N = 0 gives no results at all.
// Sequence: the normal is computed by one shared compare-subtract unit and one shared
// multiplier. The steps are normalizing (at most 30 left shifts), the two squares, the
// square root and the two divides, and then the first copy. Each copy then passes
// through the states ST_OFFX, ST_OFFY and ST_EMIT, its two products going through the
// one multiplier in turn. A zero-length segment skips the normal work and goes
// straight to its first copy.
// busy falls in the cycle in which the last result strobes, and a new request may be
// taken at the edge that ends that cycle.
// Results are shown for exactly one cycle and cannot be held off by the receiver.
// Reset clears both registers, the sequencer and the strobe.
`timescale 1ns / 1ps
`default_nettype none

module parallel_offset_line_generator
	import polg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire polg_seg_t             line,
	output polg_res_t                  result,
	output logic                       result_strobe,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_NORM = 4'd1;
	localparam logic [3:0] ST_SQA  = 4'd2;
	localparam logic [3:0] ST_SQB  = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_DIVX = 4'd5;
	localparam logic [3:0] ST_DIVY = 4'd6;
	localparam logic [3:0] ST_OFFX = 4'd7;
	localparam logic [3:0] ST_OFFY = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  copies_q;
	logic [GAP_W-1:0]  gap_q;
	polg_seg_t         line_q;
	logic [31:0]       a_q, b_q;
	logic              negx_q, negy_q, zero_q;
	logic [CNT_W-1:0]  n_q;
	logic [63:0]       rem_q, root_q, sqb_q;
	logic [31:0]       len_q;
	logic [48:0]       dd_q;
	logic [4:0]        cnt_q;
	logic [NORM_W-1:0] quo_q, mx_q, my_q;
	logic [35:0]       d_q;
	logic [36:0]       ox_q, oy_q;
	logic              side_q;
	logic [CNT_W-1:0]  idx_q;
	polg_res_t         res_q;
	logic              strobe_q;

	// Request decode.
	logic signed [32:0] dx_in, dy_in, ndx_in, ndy_in;
	logic [31:0]        ax_in, ay_in;
	logic               zero_in;
	logic [CNT_W-1:0]   n_in;

	assign dx_in   = {line.end_x[31], line.end_x} - {line.start_x[31], line.start_x};
	assign dy_in   = {line.end_y[31], line.end_y} - {line.start_y[31], line.start_y};
	assign ndx_in  = -dx_in;
	assign ndy_in  = -dy_in;
	assign ax_in   = dx_in[32] ? ndx_in[31:0] : dx_in[31:0];
	assign ay_in   = dy_in[32] ? ndy_in[31:0] : dy_in[31:0];
	assign zero_in = (dx_in == 33'sd0) && (dy_in == 33'sd0);
	assign n_in    = (copies_q > CNT_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : copies_q;

	logic [31:0] ab_or;
	assign ab_or = a_q | b_q;

	// Shared multiplier: squares during setup, distance times normal per copy.
	logic [35:0] mul_x;
	logic [30:0] mul_y;
	logic [66:0] prod;
	logic [52:0] rnd;
	logic [36:0] ofs;

	always_comb begin
		unique case (state_q)
			ST_SQA: begin
				mul_x = {5'd0, a_q[30:0]};
				mul_y = a_q[30:0];
			end
			ST_SQB: begin
				mul_x = {5'd0, b_q[30:0]};
				mul_y = b_q[30:0];
			end
			ST_OFFY: begin
				mul_x = d_q;
				mul_y = {14'd0, my_q};
			end
			default: begin
				mul_x = d_q;
				mul_y = {14'd0, mx_q};
			end
		endcase
	end

	assign prod = {31'd0, mul_x} * {36'd0, mul_y};
	assign rnd  = prod[52:0] + 53'd32768;
	assign ofs  = rnd[52:16];

	// Shared compare-subtract unit for the square root and both divides.
	logic [63:0] cs_b, diff;
	logic        ge;
	logic [63:0] root_next;
	logic [NORM_W-1:0] quo_next;
	logic [48:0] num_x_sq, num_y_len;

	assign cs_b      = (state_q == ST_SQRT) ? (root_q + sqb_q) : {15'd0, dd_q};
	assign ge        = rem_q >= cs_b;
	assign diff      = rem_q - cs_b;
	assign root_next = ge ? ((root_q >> 1) + sqb_q) : (root_q >> 1);
	assign quo_next  = {quo_q[NORM_W-2:0], ge};
	// Numerators (v * 2^17 + L); the x numerator is formed as the root settles.
	assign num_x_sq  = {1'b0, b_q[30:0], 17'd0} + {17'd0, root_next[31:0]};
	assign num_y_len = {1'b0, a_q[30:0], 17'd0} + {17'd0, len_q};

	// Left copies use the negated normal, except for a zero-length segment.
	logic cur_negx, cur_negy;
	assign cur_negx = negx_q ^ (side_q & ~zero_q);
	assign cur_negy = negy_q ^ (side_q & ~zero_q);

	function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [36:0] mag,
			input logic neg);
		logic signed [38:0] ov;
		logic signed [38:0] s;
		logic [31:0]        r;
		ov = signed'({2'b00, mag});
		if (neg) begin
			ov = -ov;
		end
		s = signed'({{7{base[31]}}, base}) + ov;
		if (!s[38] && (|s[37:31])) begin
			r = 32'h7FFF_FFFF;
		end else if (s[38] && !(&s[37:31])) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			copies_q <= '0;
			gap_q    <= '0;
			line_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			negx_q   <= 1'b0;
			negy_q   <= 1'b0;
			zero_q   <= 1'b0;
			n_q      <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			sqb_q    <= '0;
			len_q    <= '0;
			dd_q     <= '0;
			cnt_q    <= '0;
			quo_q    <= '0;
			mx_q     <= '0;
			my_q     <= '0;
			d_q      <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			side_q   <= 1'b0;
			idx_q    <= '0;
			res_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				priority if (cfg_index == REG_COPIES) begin
					copies_q <= cfg_data[CNT_W-1:0];
				end else if (cfg_index == REG_GAP) begin
					gap_q <= cfg_data[GAP_W-1:0];
				end
			end

			strobe_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						line_q <= line;
						a_q    <= ax_in;
						b_q    <= ay_in;
						negx_q <= zero_in | dy_in[32];
						negy_q <= !dx_in[32] && (dx_in != 33'sd0);
						zero_q <= zero_in;
						n_q    <= n_in;
						side_q <= 1'b0;
						idx_q  <= CNT_W'(1);
						d_q    <= {5'd0, gap_q};
						if (n_in == '0) begin
							state_q <= ST_IDLE;
						end else if (zero_in) begin
							mx_q    <= NORM_ONE;
							my_q    <= '0;
							state_q <= ST_OFFX;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					// Bring max(a, b) into [2^30, 2^31) one bit per cycle.
					if (ab_or[31:30] == 2'b00) begin
						a_q <= {a_q[30:0], 1'b0};
						b_q <= {b_q[30:0], 1'b0};
					end else begin
						if (ab_or[31]) begin
							a_q <= a_q >> 1;
							b_q <= b_q >> 1;
						end
						state_q <= ST_SQA;
					end
				end
				ST_SQA: begin
					rem_q   <= {2'b00, prod[61:0]};
					state_q <= ST_SQB;
				end
				ST_SQB: begin
					rem_q   <= rem_q + {2'b00, prod[61:0]};
					root_q  <= '0;
					sqb_q   <= 64'd1 << 62;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					root_q <= root_next;
					sqb_q  <= sqb_q >> 2;
					if (sqb_q[0]) begin
						len_q   <= root_next[31:0];
						rem_q   <= {15'd0, num_x_sq};
						dd_q    <= {root_next[31:0], 17'd0};
						cnt_q   <= 5'd16;
						quo_q   <= '0;
						state_q <= ST_DIVX;
					end else if (ge) begin
						rem_q <= diff;
					end
				end
				ST_DIVX: begin
					if (cnt_q == 5'd0) begin
						mx_q    <= quo_next;
						rem_q   <= {15'd0, num_y_len};
						dd_q    <= {len_q, 17'd0};
						cnt_q   <= 5'd16;
						quo_q   <= '0;
						state_q <= ST_DIVY;
					end else begin
						if (ge) begin
							rem_q <= diff;
						end
						dd_q  <= dd_q >> 1;
						cnt_q <= cnt_q - 5'd1;
						quo_q <= quo_next;
					end
				end
				ST_DIVY: begin
					if (cnt_q == 5'd0) begin
						my_q    <= quo_next;
						state_q <= ST_OFFX;
					end else begin
						if (ge) begin
							rem_q <= diff;
						end
						dd_q  <= dd_q >> 1;
						cnt_q <= cnt_q - 5'd1;
						quo_q <= quo_next;
					end
				end
				ST_OFFX: begin
					ox_q    <= ofs;
					state_q <= ST_OFFY;
				end
				ST_OFFY: begin
					oy_q    <= ofs;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					res_q.side        <= side_q;
					res_q.copy_index  <= idx_q;
					res_q.seg_start_x <= sat_add(line_q.start_x, ox_q, cur_negx);
					res_q.seg_start_y <= sat_add(line_q.start_y, oy_q, cur_negy);
					res_q.seg_end_x   <= sat_add(line_q.end_x, ox_q, cur_negx);
					res_q.seg_end_y   <= sat_add(line_q.end_y, oy_q, cur_negy);
					res_q.last        <= side_q && (idx_q == n_q);
					strobe_q          <= 1'b1;
					if (idx_q == n_q) begin
						if (side_q) begin
							state_q <= ST_IDLE;
						end else begin
							side_q  <= 1'b1;
							idx_q   <= CNT_W'(1);
							d_q     <= {5'd0, gap_q};
							state_q <= ST_OFFX;
						end
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						d_q     <= d_q + {5'd0, gap_q};
						state_q <= ST_OFFX;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire
